@@ rtl/byte_ring_frame_checker_macros.svh @@
// Assertion macros for the byte ring frame checker
`ifndef BYTE_RING_FRAME_CHECKER_MACROS_SVH
`define BYTE_RING_FRAME_CHECKER_MACROS_SVH

// implication checked every clock outside reset
`define BRFC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");

// implication whose consequent is checked in the next clock
`define BRFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

@@ rtl/brfc_pkg.sv @@
//------------------------------------------------------------------------------
// brfc_pkg
// Types and constants shared by the byte ring frame checker.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package brfc_pkg;

  localparam int DefRingDepth = 256;

  localparam logic [2:0] REQ_PUT   = 3'd0;
  localparam logic [2:0] REQ_GET   = 3'd1;
  localparam logic [2:0] REQ_PEEK  = 3'd2;
  localparam logic [2:0] REQ_SEEK  = 3'd3;
  localparam logic [2:0] REQ_CHECK = 3'd4;

  localparam logic [2:0] FS_OK        = 3'd0;
  localparam logic [2:0] FS_BODY_XOR  = 3'd1;
  localparam logic [2:0] FS_END_BYTE  = 3'd2;
  localparam logic [2:0] FS_INCOMPL   = 3'd3;
  localparam logic [2:0] FS_TOO_LONG  = 3'd4;
  localparam logic [2:0] FS_HDR_XOR   = 3'd5;
  localparam logic [2:0] FS_START     = 3'd6;
  localparam logic [2:0] FS_TOO_SHORT = 3'd7;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_MAXLEN = 2'd2;
  localparam logic [1:0] CFG_OVWR  = 2'd3;

  localparam int HdrBytes   = 4;
  localparam int FrameExtra = 8;
  localparam int EndOfs     = 7;
  localparam int BodyEnd    = 5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] offset;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       ok;
    logic [2:0] frame_status;
    logic [7:0] frame_length;
    logic [7:0] fill_count;
    logic [7:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [15:0] max_payload_len;
    logic        overwrite_on_full;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/brfc_if.sv @@
//------------------------------------------------------------------------------
// brfc_req_if / brfc_rsp_if / brfc_cfg_if
// Valid/ready channels of the byte ring frame checker.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface brfc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic [7:0] offset;
  modport source (output valid, req_type, data_byte, offset, input ready);
  modport sink (input valid, req_type, data_byte, offset, output ready);
endinterface

interface brfc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       ok;
  logic [2:0] frame_status;
  logic [7:0] frame_length;
  logic [7:0] fill_count;
  logic [7:0] free_count;
  modport source (output valid, read_byte, ok, frame_status, frame_length, fill_count,
                  free_count, input ready);
  modport sink (input valid, read_byte, ok, frame_status, frame_length, fill_count,
                free_count, output ready);
endinterface

interface brfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/brfc_front.sv @@
//------------------------------------------------------------------------------
// brfc_front
// Accepts request words and queues them in a two-entry queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module brfc_front
  import brfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  req_t      in_req,
  output logic      q_valid,
  input  wire logic q_pop,
  output req_t      q_req
);
  req_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_req    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/brfc_back.sv @@
//------------------------------------------------------------------------------
// brfc_back
// Ring store and request sequencer; seek and check walk the ring one byte at a time.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module brfc_back
  import brfc_pkg::*;
#(
  parameter int RING_DEPTH = DefRingDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic q_valid,
  input  req_t      q_req,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_rsp
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] MAXFILL = CW'(RING_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_SEEK = 6'b000100,
    S_CHK  = 6'b001000,
    S_WAIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  logic [7:0]    mem [RING_DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] wr_idx, rd_idx;
  state_t        state;
  req_t          req;
  logic [16:0]   pos;
  logic [16:0]   len;
  logic [7:0]    sum;
  logic [CW-1:0] fill;
  rsp_t          rsp;

  assign fill = (wr_idx >= rd_idx) ? CW'(wr_idx) - CW'(rd_idx)
              : CW'(RING_DEPTH) + CW'(wr_idx) - CW'(rd_idx);

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_at(input logic [AW-1:0] b, input logic [16:0] d);
    logic [17:0] s;
    s = 18'(b) + 18'(d);
    if (s >= 18'(RING_DEPTH)) s = s - 18'(RING_DEPTH);
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (state == S_IDLE && q_valid && q_req.req_type == REQ_PUT &&
        (fill < MAXFILL || cfg.overwrite_on_full))
      mem[wr_idx] <= q_req.data_byte;
  end

  always_comb begin
    raddr = addr_at(rd_idx, pos);
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_DONE);
  assign out_rsp   = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wr_idx <= '0;
      rd_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            req <= q_req;
            rsp <= '0;
            pos <= '0;
            sum <= '0;
            case (q_req.req_type)
              REQ_PUT: begin
                if (fill < MAXFILL) begin
                  wr_idx <= inc(wr_idx);
                  rsp.ok <= 1'b1;
                end else if (cfg.overwrite_on_full) begin
                  wr_idx <= inc(wr_idx);
                  rd_idx <= inc(rd_idx);
                  rsp.ok <= 1'b1;
                end
                state <= S_WAIT;
              end
              REQ_GET: begin
                state <= (fill != '0) ? S_READ : S_WAIT;
              end
              REQ_PEEK: begin
                pos   <= 17'(q_req.offset);
                state <= (17'(q_req.offset) < 17'(fill)) ? S_READ : S_WAIT;
              end
              REQ_SEEK: begin
                state <= (fill != '0) ? S_READ : S_WAIT;
              end
              REQ_CHECK: begin
                if (fill < CW'(FrameExtra)) begin
                  rsp.frame_status <= FS_TOO_SHORT;
                  state <= S_WAIT;
                end else state <= S_READ;
              end
              default: state <= S_WAIT;
            endcase
          end
        end
        S_READ: begin
          // memory address rd_idx + pos (wrapped) is presented; data arrives next cycle
          case (req.req_type)
            REQ_SEEK:  state <= S_SEEK;
            REQ_CHECK: state <= S_CHK;
            default:   state <= S_SEEK;
          endcase
        end
        S_SEEK: begin
          if (req.req_type == REQ_GET) begin
            rsp.read_byte <= rdata;
            rsp.ok        <= 1'b1;
            rd_idx        <= inc(rd_idx);
            state         <= S_WAIT;
          end else if (req.req_type == REQ_PEEK) begin
            rsp.read_byte <= rdata;
            rsp.ok        <= 1'b1;
            state         <= S_WAIT;
          end else if (rdata == req.data_byte) begin
            rsp.ok <= 1'b1;
            state  <= S_WAIT;
          end else begin
            rd_idx <= inc(rd_idx);
            state  <= (fill == CW'(1)) ? S_WAIT : S_READ;
          end
        end
        S_CHK: begin
          state <= S_READ;
          pos   <= pos + 17'd1;
          if (pos < 17'(HdrBytes)) sum <= sum ^ rdata;
          case (pos)
            17'd0: if (rdata != cfg.start_marker) begin
              rsp.frame_status <= FS_START;
              state <= S_WAIT;
            end
            17'd1: len[7:0] <= rdata;
            17'd2: len <= {1'b0, rdata, len[7:0]};
            17'd3: begin
              if ((sum ^ rdata) != 8'd0) begin
                rsp.frame_status <= FS_HDR_XOR;
                state <= S_WAIT;
              end else if (len[15:0] > cfg.max_payload_len) begin
                rsp.frame_status <= FS_TOO_LONG;
                state <= S_WAIT;
              end else if (18'(len) + 18'(FrameExtra) > 18'(fill)) begin
                rsp.frame_status <= FS_INCOMPL;
                state <= S_WAIT;
              end else pos <= len + 17'(EndOfs);
            end
            default: begin
              if (pos == len + 17'(EndOfs)) begin
                if (rdata != cfg.end_marker) begin
                  rsp.frame_status <= FS_END_BYTE;
                  state <= S_WAIT;
                end else pos <= 17'(HdrBytes);
              end else begin
                sum <= sum ^ rdata;
                if (pos == len + 17'(HdrBytes)) begin
                  if ((sum ^ rdata) != 8'd0) rsp.frame_status <= FS_BODY_XOR;
                  else rsp.frame_length <= 8'(len + 17'(FrameExtra));
                  state <= S_WAIT;
                end
              end
            end
          endcase
        end
        S_WAIT: begin
          rsp.fill_count <= 8'(fill);
          rsp.free_count <= 8'(MAXFILL - fill);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/byte_ring_frame_checker.sv @@
//------------------------------------------------------------------------------
// byte_ring_frame_checker
// Byte ring FIFO with put/get/peek/seek and frame check at the read end.
//------------------------------------------------------------------------------
// channel  dir  words
// req      in   req_type, data_byte, offset
// rsp      out  read_byte, ok, frame_status, frame_length, fill_count, free_count
// cfg      in   index, wdata
// Put and unknown requests pass idle, wait and done; get and peek add a read and
// a seek state; seek and check read each byte over the single store read port.
// Sync reset empties the ring; store contents are kept. A two-word queue
// keeps accepting, until it is full, while a result waits on rsp.ready.
`timescale 1ns / 1ps
`default_nettype none
module byte_ring_frame_checker
  import brfc_pkg::*;
#(
  parameter int RING_DEPTH = DefRingDepth
) (
  input wire logic clk,
  input wire logic rst,
  brfc_req_if.sink   req,
  brfc_rsp_if.source rsp,
  brfc_cfg_if.sink   cfg
);
  cfg_t cfg_reg;
  req_t in_req, q_req;
  rsp_t out_rsp;
  logic q_valid, q_pop;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= '{8'd0, 8'd0, 16'd255, 1'b0};
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_START:  cfg_reg.start_marker <= cfg.wdata[7:0];
        CFG_END:    cfg_reg.end_marker <= cfg.wdata[7:0];
        CFG_MAXLEN: cfg_reg.max_payload_len <= cfg.wdata;
        CFG_OVWR:   cfg_reg.overwrite_on_full <= cfg.wdata[0];
        default:    cfg_reg <= cfg_reg;
      endcase
    end
  end

  assign in_req = '{req.req_type, req.data_byte, req.offset};

  brfc_front u_front (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready), .in_req,
    .q_valid, .q_pop, .q_req
  );

  brfc_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk, .rst, .cfg(cfg_reg), .q_valid, .q_req, .q_pop,
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp
  );

  assign rsp.read_byte    = out_rsp.read_byte;
  assign rsp.ok           = out_rsp.ok;
  assign rsp.frame_status = out_rsp.frame_status;
  assign rsp.frame_length = out_rsp.frame_length;
  assign rsp.fill_count   = out_rsp.fill_count;
  assign rsp.free_count   = out_rsp.free_count;
endmodule
`default_nettype wire

@@ rtl/brfc_checker.sv @@
//------------------------------------------------------------------------------
// brfc_checker
// Port-level checks of the byte ring frame checker.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "byte_ring_frame_checker_macros.svh"
module brfc_checker
  import brfc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       rsp_ok,
  input wire logic [2:0] rsp_frame_status,
  input wire logic [7:0] rsp_frame_length,
  input wire logic [7:0] rsp_read_byte
);
  `BRFC_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `BRFC_ASSERT_IMP(a_len_ok, clk, rst, rsp_valid && rsp_frame_length != 8'd0,
    rsp_frame_status == FS_OK)
  `BRFC_ASSERT_IMP(a_status_no_ok, clk, rst, rsp_valid && rsp_frame_status != FS_OK,
    !rsp_ok && rsp_read_byte == 8'd0)
endmodule

bind byte_ring_frame_checker brfc_checker u_brfc_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_ok(rsp.ok), .rsp_frame_status(rsp.frame_status),
  .rsp_frame_length(rsp.frame_length), .rsp_read_byte(rsp.read_byte)
);
`default_nettype wire
